// ===== sv/calendar_clock_with_frame_key_assert.svh =====
// Assertion shorthands for the calendar clock checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef CALENDAR_CLOCK_WITH_FRAME_KEY_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_FRAME_KEY_ASSERT_SVH

// Same-cycle implication.
`define CCFK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ccfk assertion failed");

// Next-cycle implication.
`define CCFK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ccfk assertion failed");

`endif

// ===== sv/ccfk_pkg.sv =====
`default_nettype none

package ccfk_pkg;

    localparam int unsigned DAYS_PER_YEAR = 366;
    localparam int unsigned MS_PER_SEC    = 1000;
    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOUR_PER_DAY  = 24;

    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned DAY_W   = 9;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MS_W    = 10;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned DELTA_W = 32;
    localparam int unsigned KEY_W   = 50;

    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // dividend = millisecond count + elapsed, one bit per cycle
    localparam int unsigned DVD_W    = ELAPSED_W + 1;
    localparam int unsigned DIV_CNT_W = 5;
    // quotient never exceeds (999 + 65535) / 1000 = 66
    localparam int unsigned QUO_W    = 7;

    // Horner steps of x*100 + v
    localparam int unsigned KEY_STEPS = 6;

    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELTA   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_UPD,
        S_KEY,
        S_PUSH
    } t_state;

    // result beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic [DELTA_W-1:0] cur_delta;
        logic [FRAME_W-1:0] cur_frame;
        logic [MS_W-1:0]    cur_millisecond;
        logic [SEC_W-1:0]   cur_second;
        logic [MIN_W-1:0]   cur_minute;
        logic [HOUR_W-1:0]  cur_hour;
        logic [DAY_W-1:0]   cur_day;
        logic [YEAR_W-1:0]  cur_year;
        logic [KEY_W-1:0]   time_key;
    } t_result;

    localparam int unsigned RES_W = $bits(t_result);

endpackage

`default_nettype wire

// ===== sv/calendar_clock_with_frame_key.sv =====
// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+-------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: elapsed_ms
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: time key and current fields
// cfg       | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One beat is worked at a time; s_axis_tready is high only in idle. An advance beat runs
// through 17 bit-serial divide steps by 1000, the carry chain, the key (six multiply-by-100
// steps of three adder passes) and the result load. Other modes skip the divider.
// A stuck result lets the next beat be worked out; that one then waits and holds off input.
// Reset (i_rst_n low, synchronous) clears the clock, sets delta to one and
// zeroes the start registers. Configuration is always ready.
`default_nettype none

module calendar_clock_with_frame_key (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [ccfk_pkg::ELAPSED_W-1:0] s_axis_tdata,  // [15:0] elapsed_ms
    input  wire logic [ccfk_pkg::MODE_W-1:0]   s_axis_tuser,   // [1:0] mode
    // master side
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [49:0] time_key, [65:50] cur_year, [74:66] cur_day, [79:75] cur_hour,
    // [85:80] cur_minute, [91:86] cur_second, [101:92] cur_millisecond,
    // [117:102] cur_frame, [149:118] cur_delta, [151:150] zero
    output logic [ccfk_pkg::RES_W-1:0]         m_axis_tdata,
    // configuration write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ccfk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ccfk_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    // start registers
    logic [ccfk_pkg::YEAR_W-1:0]  r_start_year;
    logic [ccfk_pkg::DAY_W-1:0]   r_start_day;
    logic [ccfk_pkg::HOUR_W-1:0]  r_start_hour;
    logic [ccfk_pkg::MIN_W-1:0]   r_start_minute;
    logic [ccfk_pkg::SEC_W-1:0]   r_start_second;

    // clock state
    logic [ccfk_pkg::YEAR_W-1:0]  r_year,   n_year;
    logic [ccfk_pkg::DAY_W-1:0]   r_day,    n_day;
    logic [ccfk_pkg::HOUR_W-1:0]  r_hour,   n_hour;
    logic [ccfk_pkg::MIN_W-1:0]   r_minute, n_minute;
    logic [ccfk_pkg::SEC_W-1:0]   r_second, n_second;
    logic [ccfk_pkg::MS_W-1:0]    r_milli,  n_milli;
    logic [ccfk_pkg::FRAME_W-1:0] r_frame,  n_frame;
    logic [ccfk_pkg::DELTA_W-1:0] r_delta,  n_delta;

    // sequencer
    ccfk_pkg::t_state             r_state, n_state;
    logic [ccfk_pkg::MODE_W-1:0]  r_mode;
    logic [ccfk_pkg::DVD_W-1:0]   r_dvd,    n_dvd;     // dividend in, quotient out
    logic [ccfk_pkg::MS_W-1:0]    r_rem,    n_rem;
    logic [ccfk_pkg::DIV_CNT_W-1:0] r_bitcnt;
    logic [ccfk_pkg::KEY_W-1:0]   r_acc,    n_acc;
    logic [ccfk_pkg::KEY_W-1:0]   r_tmp,    n_tmp;
    logic [2:0]                   r_step;
    logic [1:0]                   r_phase;
    ccfk_pkg::t_result            r_out;
    logic                         r_out_valid;

    // control
    logic in_acc;
    logic div_last;
    logic key_last;
    logic push_go;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign div_last = (r_bitcnt == ccfk_pkg::DIV_CNT_W'(ccfk_pkg::DVD_W - 1));
    assign key_last = (r_step == 3'(ccfk_pkg::KEY_STEPS - 1)) && (r_phase == 2'd2);
    assign push_go  = (r_state == ccfk_pkg::S_PUSH) && (!r_out_valid || m_axis_tready);

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccfk_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (s_axis_tuser == ccfk_pkg::MODE_ADVANCE) ?
                              ccfk_pkg::S_DIV : ccfk_pkg::S_UPD;
                end
            end
            ccfk_pkg::S_DIV:  if (div_last) n_state = ccfk_pkg::S_UPD;
            ccfk_pkg::S_UPD:  n_state = ccfk_pkg::S_KEY;
            ccfk_pkg::S_KEY:  if (key_last) n_state = ccfk_pkg::S_PUSH;
            ccfk_pkg::S_PUSH: if (push_go) n_state = ccfk_pkg::S_IDLE;
            default:          n_state = ccfk_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ccfk_pkg::S_IDLE);
    end

    // datapath
    always_comb begin
        logic [ccfk_pkg::MS_W:0]   trial;
        logic                      ge;
        logic [ccfk_pkg::QUO_W-1:0] quo;
        logic [7:0]                sec_sum;
        logic [1:0]                sec_cy;
        logic [6:0]                min_sum;
        logic                      min_cy;
        logic [ccfk_pkg::HOUR_W-1:0] hour_sum;
        logic                      hour_cy;
        logic [ccfk_pkg::DAY_W-1:0]  day_sum;
        logic                      day_cy;
        logic [ccfk_pkg::KEY_W-1:0]  addend;

        n_year   = r_year;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_milli  = r_milli;
        n_frame  = r_frame;
        n_delta  = r_delta;
        n_acc    = r_acc;
        n_tmp    = r_tmp;

        // restoring divide by 1000, one quotient bit a cycle
        trial = {r_rem, r_dvd[ccfk_pkg::DVD_W-1]};
        ge    = (trial >= (ccfk_pkg::MS_W + 1)'(ccfk_pkg::MS_PER_SEC));
        n_rem = ge ? ccfk_pkg::MS_W'(trial - (ccfk_pkg::MS_W + 1)'(ccfk_pkg::MS_PER_SEC))
                   : trial[ccfk_pkg::MS_W-1:0];
        n_dvd = {r_dvd[ccfk_pkg::DVD_W-2:0], ge};

        // carry chain; a zero carry leaves each stage as it is
        quo     = r_dvd[ccfk_pkg::QUO_W-1:0];
        sec_sum = {2'b00, r_second} + {1'b0, quo};
        if (sec_sum >= 8'(2 * ccfk_pkg::SEC_PER_MIN)) begin
            sec_cy = 2'd2;
        end else if (sec_sum >= 8'(ccfk_pkg::SEC_PER_MIN)) begin
            sec_cy = 2'd1;
        end else begin
            sec_cy = 2'd0;
        end
        min_sum  = {1'b0, r_minute} + {5'b0, sec_cy};
        min_cy   = (min_sum >= 7'(ccfk_pkg::MIN_PER_HOUR));
        hour_sum = r_hour + {4'b0, min_cy};
        hour_cy  = (hour_sum >= ccfk_pkg::HOUR_W'(ccfk_pkg::HOUR_PER_DAY));
        day_sum  = r_day + {8'b0, hour_cy};
        day_cy   = (day_sum >= ccfk_pkg::DAY_W'(ccfk_pkg::DAYS_PER_YEAR));

        if (r_state == ccfk_pkg::S_UPD) begin
            case (r_mode)
                ccfk_pkg::MODE_ADVANCE: begin
                    n_delta = ccfk_pkg::DELTA_W'(1);
                    n_milli = r_rem;
                    if (quo == '0) begin
                        if (r_frame != '1) n_frame = r_frame + ccfk_pkg::FRAME_W'(1);
                    end else begin
                        n_frame  = '0;
                        n_second = ccfk_pkg::SEC_W'(sec_sum
                                   - 8'(sec_cy) * 8'(ccfk_pkg::SEC_PER_MIN));
                        n_minute = min_cy ?
                                   ccfk_pkg::MIN_W'(min_sum - 7'(ccfk_pkg::MIN_PER_HOUR)) :
                                   min_sum[ccfk_pkg::MIN_W-1:0];
                        n_hour   = hour_cy ? '0 : hour_sum;
                        n_day    = day_cy ? '0 : day_sum;
                        if (day_cy && r_year != '1) n_year = r_year + ccfk_pkg::YEAR_W'(1);
                    end
                end
                ccfk_pkg::MODE_DELTA: begin
                    if (r_delta != '1) n_delta = r_delta + ccfk_pkg::DELTA_W'(1);
                end
                ccfk_pkg::MODE_LOAD: begin
                    n_year   = r_start_year;
                    n_day    = (r_start_day > ccfk_pkg::DAY_W'(ccfk_pkg::DAYS_PER_YEAR - 1)) ?
                               ccfk_pkg::DAY_W'(ccfk_pkg::DAYS_PER_YEAR - 1) : r_start_day;
                    n_hour   = (r_start_hour > ccfk_pkg::HOUR_W'(ccfk_pkg::HOUR_PER_DAY - 1)) ?
                               ccfk_pkg::HOUR_W'(ccfk_pkg::HOUR_PER_DAY - 1) : r_start_hour;
                    n_minute = (r_start_minute > ccfk_pkg::MIN_W'(ccfk_pkg::MIN_PER_HOUR - 1)) ?
                               ccfk_pkg::MIN_W'(ccfk_pkg::MIN_PER_HOUR - 1) : r_start_minute;
                    n_second = (r_start_second > ccfk_pkg::SEC_W'(ccfk_pkg::SEC_PER_MIN - 1)) ?
                               ccfk_pkg::SEC_W'(ccfk_pkg::SEC_PER_MIN - 1) : r_start_second;
                    n_milli  = '0;
                    n_frame  = '0;
                    n_delta  = ccfk_pkg::DELTA_W'(1);
                end
                default: ;  // unused mode: clock holds
            endcase
            n_acc = ccfk_pkg::KEY_W'(n_day);
        end

        // key: acc = acc*100 + v as acc*3, then (acc*3)*32 + acc*4, then + v
        case (r_step)
            3'd0:    addend = ccfk_pkg::KEY_W'(r_hour);
            3'd1:    addend = ccfk_pkg::KEY_W'(r_minute);
            3'd2:    addend = ccfk_pkg::KEY_W'(r_second);
            3'd3:    addend = ccfk_pkg::KEY_W'(r_frame);
            3'd5:    addend = ccfk_pkg::KEY_W'(r_delta);
            default: addend = '0;   // second half of the *10000
        endcase
        if (r_state == ccfk_pkg::S_KEY) begin
            case (r_phase)
                2'd0:    n_tmp = r_acc + (r_acc << 1);
                2'd1:    n_tmp = (r_tmp << 5) + (r_acc << 2);
                default: n_acc = r_tmp + addend;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ccfk_pkg::S_IDLE;
            r_out_valid    <= 1'b0;
            r_start_year   <= '0;
            r_start_day    <= '0;
            r_start_hour   <= '0;
            r_start_minute <= '0;
            r_start_second <= '0;
            r_year         <= '0;
            r_day          <= '0;
            r_hour         <= '0;
            r_minute       <= '0;
            r_second       <= '0;
            r_milli        <= '0;
            r_frame        <= '0;
            r_delta        <= ccfk_pkg::DELTA_W'(1);
            r_bitcnt       <= '0;
            r_step         <= '0;
            r_phase        <= '0;
        end else begin
            r_state  <= n_state;
            r_year   <= n_year;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_milli  <= n_milli;
            r_frame  <= n_frame;
            r_delta  <= n_delta;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ccfk_pkg::CFG_START_YEAR:   r_start_year   <= i_cfg_data;
                    ccfk_pkg::CFG_START_DAY:    r_start_day    <= i_cfg_data[ccfk_pkg::DAY_W-1:0];
                    ccfk_pkg::CFG_START_HOUR:   r_start_hour   <= i_cfg_data[ccfk_pkg::HOUR_W-1:0];
                    ccfk_pkg::CFG_START_MINUTE: r_start_minute <= i_cfg_data[ccfk_pkg::MIN_W-1:0];
                    ccfk_pkg::CFG_START_SECOND: r_start_second <= i_cfg_data[ccfk_pkg::SEC_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ccfk_pkg::S_DIV) begin
                r_bitcnt <= r_bitcnt + ccfk_pkg::DIV_CNT_W'(1);
            end else begin
                r_bitcnt <= '0;
            end

            if (r_state == ccfk_pkg::S_KEY) begin
                if (r_phase == 2'd2) begin
                    r_phase <= '0;
                    r_step  <= r_step + 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else begin
                r_phase <= '0;
                r_step  <= '0;
            end

            if (push_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= s_axis_tuser;
            r_dvd  <= ccfk_pkg::DVD_W'(r_milli) + ccfk_pkg::DVD_W'(s_axis_tdata);
            r_rem  <= '0;
        end else if (r_state == ccfk_pkg::S_DIV) begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
        end
        r_acc <= n_acc;
        r_tmp <= n_tmp;
        if (push_go) begin
            r_out.pad             <= '0;
            r_out.time_key        <= r_acc;
            r_out.cur_year        <= r_year;
            r_out.cur_day         <= r_day;
            r_out.cur_hour        <= r_hour;
            r_out.cur_minute      <= r_minute;
            r_out.cur_second      <= r_second;
            r_out.cur_millisecond <= r_milli;
            r_out.cur_frame       <= r_frame;
            r_out.cur_delta       <= r_delta;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ccfk_checker.sv =====
`default_nettype none

`include "calendar_clock_with_frame_key_assert.svh"

module ccfk_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [ccfk_pkg::RES_W-1:0]    m_axis_tdata
);

    ccfk_pkg::t_result w_res;

    assign w_res = ccfk_pkg::t_result'(m_axis_tdata);

    // stalled result beat holds
    `CCFK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // one item at a time: busy right after a beat is taken
    `CCFK_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // every reported day and time of day lies within its range
    `CCFK_ASSERT_NOW(a_fields_in_range, m_axis_tvalid,
        (w_res.cur_hour < ccfk_pkg::HOUR_W'(ccfk_pkg::HOUR_PER_DAY)) &&
        (w_res.cur_minute < ccfk_pkg::MIN_W'(ccfk_pkg::MIN_PER_HOUR)) &&
        (w_res.cur_second < ccfk_pkg::SEC_W'(ccfk_pkg::SEC_PER_MIN)) &&
        (w_res.cur_millisecond < ccfk_pkg::MS_W'(ccfk_pkg::MS_PER_SEC)) &&
        (w_res.cur_day < ccfk_pkg::DAY_W'(ccfk_pkg::DAYS_PER_YEAR)))

    // delta starts at one and saturates, so it is never zero
    `CCFK_ASSERT_NOW(a_delta_nonzero, m_axis_tvalid, w_res.cur_delta != '0)

endmodule

bind calendar_clock_with_frame_key ccfk_checker u_ccfk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
